>>> hdl/sfrc_pkg.sv
`default_nettype none

package sfrc_pkg;

   localparam int BUFFER_BYTES = 256;
   localparam int LEN_W        = $clog2(BUFFER_BYTES) + 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W   = 2;

   localparam logic [7:0] TIMER_STOPPED     = 8'hFE;
   localparam logic [7:0] SHORT_TIMEOUT_RST = 8'd2;
   localparam logic [7:0] CMD_LENGTH_RST    = 8'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_TIMEOUT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMMAND_LENGTH = 2'd1;

   localparam logic [2:0] MODE_CODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_CODE_CMD_READY  = 3'd1;
   localparam logic [2:0] MODE_CODE_CMD_ERR    = 3'd2;
   localparam logic [2:0] MODE_CODE_RX_DATA    = 3'd3;
   localparam logic [2:0] MODE_CODE_DATA_READY = 3'd4;
   localparam logic [2:0] MODE_CODE_DATA_ERR   = 3'd5;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_ARM   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      RX_IDLE       = 6'b000001,
      RX_CMD_READY  = 6'b000010,
      RX_CMD_ERR    = 6'b000100,
      RX_DATA       = 6'b001000,
      RX_DATA_READY = 6'b010000,
      RX_DATA_ERR   = 6'b100000
   } rx_mode_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [7:0]       data_byte;
      logic             line_high;
      logic [LEN_W-1:0] length;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_value;
      logic       frame_done;
      logic       checksum_ok;
      logic       speed_high;
      logic       timed_out;
   } result_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > LEN_W'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES) : len;
   endfunction

   function automatic logic [7:0] eac_add(input logic [7:0] sum, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, sum} + {1'b0, b};
      return t[7:0] + {7'd0, t[8]};
   endfunction

   function automatic logic [2:0] mode_code(input rx_mode_type m);
      logic [2:0] code;
      case (m)
         RX_IDLE:       code = MODE_CODE_IDLE;
         RX_CMD_READY:  code = MODE_CODE_CMD_READY;
         RX_CMD_ERR:    code = MODE_CODE_CMD_ERR;
         RX_DATA:       code = MODE_CODE_RX_DATA;
         RX_DATA_READY: code = MODE_CODE_DATA_READY;
         RX_DATA_ERR:   code = MODE_CODE_DATA_ERR;
         default:       code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> hdl/sfrc_if.sv
`default_nettype none

interface sfrc_req_if import sfrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       command;
   logic [7:0]       data_byte;
   logic             cmd_line_high;
   logic [LEN_W-1:0] block_length;

   modport source (output valid, command, data_byte, cmd_line_high, block_length,
                   input ready);
   modport sink   (input valid, command, data_byte, cmd_line_high, block_length,
                   output ready);
endinterface

interface sfrc_rsp_if import sfrc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       store_valid;
   logic [7:0] store_index;
   logic [7:0] store_value;
   logic       frame_done;
   logic       checksum_ok;
   logic       speed_high;
   logic       timed_out;

   modport source (output valid, mode, store_valid, store_index, store_value,
                   frame_done, checksum_ok, speed_high, timed_out, input ready);
   modport sink   (input valid, mode, store_valid, store_index, store_value,
                   frame_done, checksum_ok, speed_high, timed_out, output ready);
endinterface

interface sfrc_csr_if import sfrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [7:0]            wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

>>> hdl/sfrc_front.sv
`default_nettype none

module sfrc_front import sfrc_pkg::*; (
   sfrc_req_if.sink  req,
   input  logic      q_ready,
   output push_type  push
);

   always_comb begin
      req.ready          = q_ready;
      push.valid         = req.valid && q_ready;
      push.op.cmd        = cmd_type'(req.command);
      push.op.data_byte  = req.data_byte;
      push.op.line_high  = req.cmd_line_high;
      push.op.length     = clamp_len(req.block_length);
   end

endmodule

`default_nettype wire

>>> hdl/sfrc_queue.sv
`default_nettype none

module sfrc_queue import sfrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     q_ready,
   input  logic     pop,
   output head_type head
);

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_ready    = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign do_push    = push.valid;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sfrc_back.sv
`default_nettype none

module sfrc_back import sfrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  head_type    head,
   output logic        pop,
   sfrc_csr_if.sink    csr,
   sfrc_rsp_if.source  rsp
);

   rx_mode_type      rx_mode_ff, rx_mode_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] exp_len_ff, exp_len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       tmo_ff, tmo_in;
   logic             speed_ff, speed_in;
   logic [7:0]       short_tmo_ff;
   logic [7:0]       cmd_len_ff;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, res;
   logic             fire;
   logic             cmd_frame;
   logic             data_frame;
   logic             ok;
   logic [7:0]       tmo_dec;

   assign fire = head.valid && (!out_valid_ff || rsp.ready);
   assign pop  = fire;

   assign csr.ready = 1'b1;

   always_comb begin
      rx_mode_in = rx_mode_ff;
      pos_in     = pos_ff;
      exp_len_in = exp_len_ff;
      sum_in     = sum_ff;
      tmo_in     = tmo_ff;
      speed_in   = speed_ff;
      res        = '0;
      cmd_frame  = !head.op.line_high && (rx_mode_ff == RX_IDLE);
      data_frame = head.op.line_high && (rx_mode_ff == RX_DATA);
      ok         = (sum_ff == head.op.data_byte);
      tmo_dec    = (tmo_ff != 8'd0) ? tmo_ff - 8'd1 : tmo_ff;

      case (head.op.cmd)
         CMD_BYTE: begin
            if (cmd_frame || data_frame) begin
               if (pos_ff < exp_len_ff) begin
                  tmo_in          = short_tmo_ff;
                  res.store_valid = 1'b1;
                  res.store_index = pos_ff[7:0];
                  res.store_value = head.op.data_byte;
                  sum_in          = eac_add(sum_ff, head.op.data_byte);
                  pos_in          = pos_ff + 1'b1;
               end else begin
                  tmo_in          = TIMER_STOPPED;
                  res.frame_done  = 1'b1;
                  res.checksum_ok = ok;
                  if (cmd_frame) begin
                     rx_mode_in = ok ? RX_CMD_READY : RX_CMD_ERR;
                  end else begin
                     rx_mode_in = ok ? RX_DATA_READY : RX_DATA_ERR;
                     speed_in   = speed_ff ^ !ok;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (tmo_ff != TIMER_STOPPED) begin
               tmo_in = tmo_dec;
               if (tmo_dec == 8'd0) begin
                  res.timed_out = 1'b1;
                  speed_in      = !speed_ff;
                  rx_mode_in    = RX_IDLE;
                  tmo_in        = TIMER_STOPPED;
                  exp_len_in    = clamp_len({1'b0, cmd_len_ff});
                  pos_in        = '0;
                  sum_in        = '0;
               end
            end
         end
         CMD_ARM: begin
            exp_len_in = head.op.length;
            pos_in     = '0;
            sum_in     = '0;
            rx_mode_in = RX_DATA;
            tmo_in     = short_tmo_ff;
         end
         CMD_CLEAR: begin
            rx_mode_in = RX_IDLE;
            tmo_in     = TIMER_STOPPED;
            exp_len_in = clamp_len({1'b0, cmd_len_ff});
            pos_in     = '0;
            sum_in     = '0;
         end
         default: begin
            rx_mode_in = rx_mode_ff;
         end
      endcase

      res.mode       = mode_code(rx_mode_in);
      res.speed_high = speed_in;

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_mode_ff   <= RX_IDLE;
         pos_ff       <= '0;
         exp_len_ff   <= clamp_len({1'b0, CMD_LENGTH_RST});
         sum_ff       <= '0;
         tmo_ff       <= TIMER_STOPPED;
         speed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            rx_mode_ff <= rx_mode_in;
            pos_ff     <= pos_in;
            exp_len_ff <= exp_len_in;
            sum_ff     <= sum_in;
            tmo_ff     <= tmo_in;
            speed_ff   <= speed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_tmo_ff <= SHORT_TIMEOUT_RST;
         cmd_len_ff   <= CMD_LENGTH_RST;
      end else if (csr.valid) begin
         if (csr.addr == CSR_SHORT_TIMEOUT) begin
            short_tmo_ff <= csr.wdata;
         end else if (csr.addr == CSR_COMMAND_LENGTH) begin
            cmd_len_ff <= csr.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= res;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.mode        = out_ff.mode;
   assign rsp.store_valid = out_ff.store_valid;
   assign rsp.store_index = out_ff.store_index;
   assign rsp.store_value = out_ff.store_value;
   assign rsp.frame_done  = out_ff.frame_done;
   assign rsp.checksum_ok = out_ff.checksum_ok;
   assign rsp.speed_high  = out_ff.speed_high;
   assign rsp.timed_out   = out_ff.timed_out;

endmodule

`default_nettype wire

>>> hdl/serial_frame_receiver_checksum.sv
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    command, data_byte, cmd_line_high, block_length
// rsp_ch   out  valid/ready    mode, store_*, frame_done, checksum_ok, speed_high, timed_out
// csr_ch   in   valid/ready    addr (0 short_timeout, 1 command_length), wdata
//
// One item per cycle sustained while rsp_ch is ready; a result passes through the item
// queue and then the result register.
// Frame state updates once per item in the back end.
// Synchronous reset; csr_ch is always ready.
// A stalled rsp_ch holds its result; the two-entry queue absorbs items until full.
`default_nettype none

module serial_frame_receiver_checksum import sfrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sfrc_req_if.sink   req_ch,
   sfrc_rsp_if.source rsp_ch,
   sfrc_csr_if.sink   csr_ch
);

   push_type push;
   head_type head;
   logic     q_ready;
   logic     pop;

   sfrc_front u_front (
      .req     (req_ch),
      .q_ready (q_ready),
      .push    (push)
   );

   sfrc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_ready (q_ready),
      .pop     (pop),
      .head    (head)
   );

   sfrc_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .csr   (csr_ch),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

>>> hdl/sfrc_checker.sv
`default_nettype none

module sfrc_checker import sfrc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_mode,
   input logic       rsp_store_valid,
   input logic       rsp_frame_done,
   input logic       rsp_checksum_ok,
   input logic       rsp_timed_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode))
      else $error("rsp transfer dropped while stalled");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> !rsp_checksum_ok)
      else $error("checksum_ok without frame end");

   a_done_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_mode != MODE_CODE_IDLE && rsp_mode != MODE_CODE_RX_DATA && !rsp_store_valid)
      else $error("frame end with wrong mode or stored byte");

   a_timeout_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |->
         rsp_mode == MODE_CODE_IDLE && !rsp_store_valid && !rsp_frame_done)
      else $error("timeout did not return to idle");

   a_store_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_valid |->
         rsp_mode == MODE_CODE_IDLE || rsp_mode == MODE_CODE_RX_DATA)
      else $error("byte stored outside a receiving mode");

endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_mode        (rsp_ch.mode),
   .rsp_store_valid (rsp_ch.store_valid),
   .rsp_frame_done  (rsp_ch.frame_done),
   .rsp_checksum_ok (rsp_ch.checksum_ok),
   .rsp_timed_out   (rsp_ch.timed_out)
);

`default_nettype wire
